/* hdl/yfs_pkg.sv */
// yfs_pkg: shared widths, caps, colour coefficients and the beat type for the
// YUYV frame statistics block. No dependencies.
`timescale 1ns / 1ps

package yfs_pkg;

	// Largest frame the accumulator caps are sized for, in pixels
	localparam longint MAX_PIXELS = 64'd65536;

	localparam int LUMA_W = 24;
	localparam int RED_W  = 23;
	localparam int GB_W   = 24;
	localparam int CNT_W  = 17;

	localparam logic [7:0] EDGE_THRESHOLD_RESET = 8'd20;

	// Fixed-point colour coefficients, scale 1024
	localparam logic signed [11:0] COEF_RV = 12'sd1436;
	localparam logic signed [11:0] COEF_GU = 12'sd352;
	localparam logic signed [11:0] COEF_GV = 12'sd731;
	localparam logic signed [11:0] COEF_BU = 12'sd1814;
	localparam int COEF_SHIFT = 10;

	function automatic longint cap_of(input longint frame_max, input longint width_max);
		return (frame_max < width_max) ? frame_max : width_max;
	endfunction

	localparam longint LUMA_CAP_L = cap_of(MAX_PIXELS * 255, (64'd1 << LUMA_W) - 1);
	localparam longint RED_CAP_L  = cap_of((MAX_PIXELS / 2) * 255, (64'd1 << RED_W) - 1);
	localparam longint GB_CAP_L   = cap_of((MAX_PIXELS / 2) * 510, (64'd1 << GB_W) - 1);
	localparam longint CNT_CAP_L  = cap_of(MAX_PIXELS, (64'd1 << CNT_W) - 1);

	localparam logic [LUMA_W-1:0] LUMA_CAP = LUMA_W'(LUMA_CAP_L);
	localparam logic [RED_W-1:0]  RED_CAP  = RED_W'(RED_CAP_L);
	localparam logic [GB_W-1:0]   GB_CAP   = GB_W'(GB_CAP_L);
	localparam logic [CNT_W-1:0]  CNT_CAP  = CNT_W'(CNT_CAP_L);

	// Per-group contributions handed to the accumulators
	typedef struct packed {
		logic       last;
		logic [8:0] luma_add;
		logic [7:0] red;
		logic [8:0] green_blue;
		logic [1:0] edges;
	} stat_beat_t;

endpackage

/* hdl/yfs_color.sv */
// yfs_color: YUV to clamped R and G+B for one group, fixed point, no state.
// Depends on yfs_pkg for the coefficients.
`timescale 1ns / 1ps

module yfs_color (
	input  logic [7:0] luma,
	input  logic [7:0] chroma_blue,
	input  logic [7:0] chroma_red,
	output logic [7:0] red,
	output logic [8:0] green_blue
);
	import yfs_pkg::*;

	function automatic logic [7:0] clamp8(input logic signed [10:0] x);
		logic [7:0] res;
		if (x < 0) begin
			res = 8'd0;
		end else if (x > 11'sd255) begin
			res = 8'd255;
		end else begin
			res = x[7:0];
		end
		return res;
	endfunction

	logic signed [7:0]  u_off;
	logic signed [7:0]  v_off;
	logic signed [19:0] prod_r;
	logic signed [19:0] prod_g;
	logic signed [19:0] prod_b;
	logic signed [10:0] y_s;
	logic signed [10:0] r_raw;
	logic signed [10:0] g_raw;
	logic signed [10:0] b_raw;
	logic [7:0]         green;
	logic [7:0]         blue;

	// Offset 128 removal is an MSB flip
	assign u_off = $signed({~chroma_blue[7], chroma_blue[6:0]});
	assign v_off = $signed({~chroma_red[7], chroma_red[6:0]});

	assign prod_r = 20'(COEF_RV) * 20'(v_off);
	assign prod_g = 20'(COEF_GU) * 20'(u_off) + 20'(COEF_GV) * 20'(v_off);
	assign prod_b = 20'(COEF_BU) * 20'(u_off);

	assign y_s = $signed({3'b000, luma});

	// Arithmetic shift gives floor division for negative products
	assign r_raw = y_s + 11'(prod_r >>> COEF_SHIFT);
	assign g_raw = y_s - 11'(prod_g >>> COEF_SHIFT);
	assign b_raw = y_s + 11'(prod_b >>> COEF_SHIFT);

	assign red        = clamp8(r_raw);
	assign green      = clamp8(g_raw);
	assign blue       = clamp8(b_raw);
	assign green_blue = {1'b0, green} + {1'b0, blue};

endmodule

/* hdl/yfs_accum.sv */
// yfs_accum: saturating frame accumulators and the result register.
// Depends on yfs_pkg for widths, caps and stat_beat_t.
`timescale 1ns / 1ps

module yfs_accum (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       beat_valid,
	input  yfs_pkg::stat_beat_t        beat,
	output logic                       hold,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [yfs_pkg::LUMA_W-1:0] luma_total,
	output logic [yfs_pkg::RED_W-1:0]  red_total,
	output logic [yfs_pkg::GB_W-1:0]   green_blue_total,
	output logic [yfs_pkg::CNT_W-1:0]  edge_total,
	output logic [yfs_pkg::CNT_W-1:0]  pixel_total
);
	import yfs_pkg::*;

	logic [LUMA_W-1:0] luma_acc_q;
	logic [RED_W-1:0]  red_acc_q;
	logic [GB_W-1:0]   gb_acc_q;
	logic [CNT_W-1:0]  edge_acc_q;
	logic [CNT_W-1:0]  pixel_acc_q;

	logic [LUMA_W:0] luma_sum;
	logic [RED_W:0]  red_sum;
	logic [GB_W:0]   gb_sum;
	logic [CNT_W:0]  edge_sum;
	logic [CNT_W:0]  pixel_sum;

	logic [LUMA_W-1:0] luma_nxt;
	logic [RED_W-1:0]  red_nxt;
	logic [GB_W-1:0]   gb_nxt;
	logic [CNT_W-1:0]  edge_nxt;
	logic [CNT_W-1:0]  pixel_nxt;

	logic result_valid_q;
	logic take;

	// A frame end cannot land while the previous result is still unclaimed
	assign hold = beat_valid && beat.last && result_valid_q && result_stall;
	assign take = beat_valid && !hold;

	always_comb begin
		luma_sum  = {1'b0, luma_acc_q} + (LUMA_W+1)'(beat.luma_add);
		red_sum   = {1'b0, red_acc_q} + (RED_W+1)'(beat.red);
		gb_sum    = {1'b0, gb_acc_q} + (GB_W+1)'(beat.green_blue);
		edge_sum  = {1'b0, edge_acc_q} + (CNT_W+1)'(beat.edges);
		pixel_sum = {1'b0, pixel_acc_q} + (CNT_W+1)'(2);

		luma_nxt  = (luma_sum > (LUMA_W+1)'(LUMA_CAP)) ? LUMA_CAP : luma_sum[LUMA_W-1:0];
		red_nxt   = (red_sum > (RED_W+1)'(RED_CAP)) ? RED_CAP : red_sum[RED_W-1:0];
		gb_nxt    = (gb_sum > (GB_W+1)'(GB_CAP)) ? GB_CAP : gb_sum[GB_W-1:0];
		edge_nxt  = (edge_sum > (CNT_W+1)'(CNT_CAP)) ? CNT_CAP : edge_sum[CNT_W-1:0];
		pixel_nxt = (pixel_sum > (CNT_W+1)'(CNT_CAP)) ? CNT_CAP : pixel_sum[CNT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			luma_acc_q  <= '0;
			red_acc_q   <= '0;
			gb_acc_q    <= '0;
			edge_acc_q  <= '0;
			pixel_acc_q <= '0;
		end else if (take) begin
			if (beat.last) begin
				luma_acc_q  <= '0;
				red_acc_q   <= '0;
				gb_acc_q    <= '0;
				edge_acc_q  <= '0;
				pixel_acc_q <= '0;
			end else begin
				luma_acc_q  <= luma_nxt;
				red_acc_q   <= red_nxt;
				gb_acc_q    <= gb_nxt;
				edge_acc_q  <= edge_nxt;
				pixel_acc_q <= pixel_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= (result_valid_q && result_stall) || (take && beat.last);
		end
	end

	// Totals include the closing group
	always_ff @(posedge clk) begin
		if (take && beat.last) begin
			luma_total       <= luma_nxt;
			red_total        <= red_nxt;
			green_blue_total <= gb_nxt;
			edge_total       <= edge_nxt;
			pixel_total      <= pixel_nxt;
		end
	end

	assign result_valid = result_valid_q;

endmodule

/* hdl/yuyv_frame_statistics_top.sv */
// yuyv_frame_statistics_top: input register, colour and edge stage, accumulators.
// Depends on yfs_pkg, yfs_color and yfs_accum.
`timescale 1ns / 1ps

// One YUYV group is taken per clock. Each beat passes an input register, a stage
// that forms clamped R, G+B, the luma pair sum and the edge count, and then the
// saturating accumulators; the frame totals appear on the result channel once the
// group marked last has passed the input and stage registers. The input is stalled
// only when a frame result is still waiting on the result channel and the next
// frame end has reached the accumulators. Edge tests use the threshold register
// (reset 20); write it only while no group is in flight.
module yuyv_frame_statistics_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write_en,
	input  logic [7:0]                 cfg_write_data,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [7:0]                 luma_first,
	input  logic [7:0]                 chroma_blue,
	input  logic [7:0]                 luma_second,
	input  logic [7:0]                 chroma_red,
	input  logic                       last_group,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic [yfs_pkg::LUMA_W-1:0] luma_total,
	output logic [yfs_pkg::RED_W-1:0]  red_total,
	output logic [yfs_pkg::GB_W-1:0]   green_blue_total,
	output logic [yfs_pkg::CNT_W-1:0]  edge_total,
	output logic [yfs_pkg::CNT_W-1:0]  pixel_total
);
	import yfs_pkg::*;

	logic [7:0] threshold_q;
	logic [7:0] prev_luma_q;
	logic       frame_start_q;

	logic       valid_s1;
	logic [7:0] y0_s1;
	logic [7:0] u_s1;
	logic [7:0] y1_s1;
	logic [7:0] v_s1;
	logic       last_s1;
	logic [7:0] prev_s1;
	logic       first_s1;

	logic       valid_s2;
	stat_beat_t beat_s2;

	logic       hold;
	logic       advance;
	logic       accept;
	logic [7:0] red_c;
	logic [8:0] gb_c;
	logic [7:0] diff_prev;
	logic [7:0] diff_pair;
	logic [1:0] edges_c;

	assign advance    = !hold;
	assign item_stall = hold;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= EDGE_THRESHOLD_RESET;
		end else if (cfg_write_en) begin
			threshold_q <= cfg_write_data;
		end
	end

	// Edge context follows accepted beats; a frame end restarts it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_luma_q   <= '0;
			frame_start_q <= 1'b1;
		end else if (accept) begin
			prev_luma_q   <= last_group ? 8'd0 : luma_second;
			frame_start_q <= last_group;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			y0_s1    <= luma_first;
			u_s1     <= chroma_blue;
			y1_s1    <= luma_second;
			v_s1     <= chroma_red;
			last_s1  <= last_group;
			prev_s1  <= prev_luma_q;
			first_s1 <= frame_start_q;
		end
	end

	yfs_color u_color (
		.luma        (y0_s1),
		.chroma_blue (u_s1),
		.chroma_red  (v_s1),
		.red         (red_c),
		.green_blue  (gb_c)
	);

	always_comb begin
		diff_prev = (y0_s1 > prev_s1) ? (y0_s1 - prev_s1) : (prev_s1 - y0_s1);
		diff_pair = (y1_s1 > y0_s1) ? (y1_s1 - y0_s1) : (y0_s1 - y1_s1);
		if (first_s1) begin
			edges_c = 2'd0;
		end else begin
			edges_c = 2'((diff_prev > threshold_q)) + 2'((diff_pair > threshold_q));
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			beat_s2.last       <= last_s1;
			beat_s2.luma_add   <= {1'b0, y0_s1} + {1'b0, y1_s1};
			beat_s2.red        <= red_c;
			beat_s2.green_blue <= gb_c;
			beat_s2.edges      <= edges_c;
		end
	end

	yfs_accum u_accum (
		.clk              (clk),
		.arst_n           (arst_n),
		.beat_valid       (valid_s2),
		.beat             (beat_s2),
		.hold             (hold),
		.result_valid     (result_valid),
		.result_stall     (result_stall),
		.luma_total       (luma_total),
		.red_total        (red_total),
		.green_blue_total (green_blue_total),
		.edge_total       (edge_total),
		.pixel_total      (pixel_total)
	);

	// A result only ever follows a frame end leaving the accumulation stage
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(valid_s2 && beat_s2.last))
		else $error("result without a frame end");

	// Input back-pressure only comes from an unclaimed result
	assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (result_valid && result_stall && valid_s2 && beat_s2.last))
		else $error("input stalled without cause");

	// Every frame holds at least one group
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (pixel_total >= CNT_W'(2)))
		else $error("frame total with no pixels");

endmodule
